// File: src/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

  // Field widths of the pixel and the result
  localparam int unsigned ByteW  = 8;
  localparam int unsigned HueW   = 15;
  localparam int unsigned SatW   = 17;
  // Integer bits of a hue below a full turn (360 < 2^9)
  localparam int unsigned HueIntW = 9;
  // Sector width in degrees and full turn in degrees
  localparam int unsigned SectorDeg = 60;
  localparam int unsigned TurnDeg   = 360;
  // Width of the sector numerator n (n < 6 * 255) and of n * 60
  localparam int unsigned SecNumW = 11;
  localparam int unsigned DegNumW = 17;

  // One restoring division step: shifted partial remainder t against divisor d.
  // Returns {quotient bit, new remainder}.
  function automatic logic [ByteW:0] div_step(logic [ByteW:0] t, logic [ByteW-1:0] d);
    logic [ByteW:0] diff;
    logic [ByteW:0] res;
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      res = {1'b1, diff[ByteW-1:0]};
    end else begin
      res = {1'b0, t[ByteW-1:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/rhc_front.sv
`default_nettype none

module rhc_front
  import rhc_pkg::*;
#(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SAT_FRAC_BITS = 16,
  parameter int unsigned QW            = 17
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [ByteW-1:0]  red_i,
  input  wire logic [ByteW-1:0]  green_i,
  input  wire logic [ByteW-1:0]  blue_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [ByteW-1:0]       hue_rem_o,
  output logic [QW-1:0]          hue_work_o,
  output logic [ByteW-1:0]       hue_den_o,
  output logic [ByteW-1:0]       sat_rem_o,
  output logic [QW-1:0]          sat_work_o,
  output logic [ByteW-1:0]       sat_den_o
);

  localparam int unsigned NumW = QW + ByteW;

  logic                 valid_q;
  logic [ByteW-1:0]     mx, mn, chroma;
  logic [SecNumW-1:0]   c_ext, sec_num;
  logic [DegNumW-1:0]   deg_num;
  logic [NumW-1:0]      hue_num, sat_num;
  logic [ByteW-1:0]     hue_rem_q, sat_rem_q, hue_den_q, sat_den_q;
  logic [QW-1:0]        hue_work_q, sat_work_q;

  // Max, min, chroma, hue numerator in sixths of a turn, then the scaled numerators
  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    chroma = mx - mn;
    c_ext  = SecNumW'(chroma);

    priority if (red_i >= green_i && red_i >= blue_i) begin
      if (green_i >= blue_i) begin
        sec_num = SecNumW'(green_i) - SecNumW'(blue_i);
      end else begin
        sec_num = SecNumW'(6) * c_ext - (SecNumW'(blue_i) - SecNumW'(green_i));
      end
    end else if (green_i >= blue_i) begin
      sec_num = SecNumW'(2) * c_ext + SecNumW'(blue_i) - SecNumW'(red_i);
    end else begin
      sec_num = SecNumW'(4) * c_ext + SecNumW'(red_i) - SecNumW'(green_i);
    end

    deg_num = DegNumW'(sec_num) * DegNumW'(SectorDeg);
    hue_num = NumW'(deg_num) << HUE_FRAC_BITS;
    sat_num = NumW'(chroma) << SAT_FRAC_BITS;
  end

  assign ready_o = !valid_q || ready_i;

  // Hold the valid flag until the first cell takes the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Split each numerator into the starting remainder and the bits still to shift in
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      hue_rem_q  <= hue_num[NumW-1:QW];
      hue_work_q <= hue_num[QW-1:0];
      hue_den_q  <= chroma;
      sat_rem_q  <= sat_num[NumW-1:QW];
      sat_work_q <= sat_num[QW-1:0];
      sat_den_q  <= mx;
    end
  end

  assign valid_o    = valid_q;
  assign hue_rem_o  = hue_rem_q;
  assign hue_work_o = hue_work_q;
  assign hue_den_o  = hue_den_q;
  assign sat_rem_o  = sat_rem_q;
  assign sat_work_o = sat_work_q;
  assign sat_den_o  = sat_den_q;

endmodule

`default_nettype wire

// File: src/rhc_div_cell.sv
`default_nettype none

module rhc_div_cell
  import rhc_pkg::*;
#(
  parameter int unsigned QW = 17
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [ByteW-1:0]  hue_rem_i,
  input  wire logic [QW-1:0]     hue_work_i,
  input  wire logic [ByteW-1:0]  hue_den_i,
  input  wire logic [ByteW-1:0]  sat_rem_i,
  input  wire logic [QW-1:0]     sat_work_i,
  input  wire logic [ByteW-1:0]  sat_den_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [ByteW-1:0]       hue_rem_o,
  output logic [QW-1:0]          hue_work_o,
  output logic [ByteW-1:0]       hue_den_o,
  output logic [ByteW-1:0]       sat_rem_o,
  output logic [QW-1:0]          sat_work_o,
  output logic [ByteW-1:0]       sat_den_o
);

  logic             valid_q;
  logic [ByteW:0]   hue_step, sat_step;
  logic [ByteW-1:0] hue_rem_q, sat_rem_q, hue_den_q, sat_den_q;
  logic [QW-1:0]    hue_work_q, sat_work_q;

  // One quotient bit for each divider: bring down the next numerator bit
  always_comb begin
    hue_step = div_step({hue_rem_i, hue_work_i[QW-1]}, hue_den_i);
    sat_step = div_step({sat_rem_i, sat_work_i[QW-1]}, sat_den_i);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Shift the quotient bit in at the bottom as the numerator bit leaves the top
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      hue_rem_q  <= hue_step[ByteW-1:0];
      hue_work_q <= {hue_work_i[QW-2:0], hue_step[ByteW]};
      hue_den_q  <= hue_den_i;
      sat_rem_q  <= sat_step[ByteW-1:0];
      sat_work_q <= {sat_work_i[QW-2:0], sat_step[ByteW]};
      sat_den_q  <= sat_den_i;
    end
  end

  assign valid_o    = valid_q;
  assign hue_rem_o  = hue_rem_q;
  assign hue_work_o = hue_work_q;
  assign hue_den_o  = hue_den_q;
  assign sat_rem_o  = sat_rem_q;
  assign sat_work_o = sat_work_q;
  assign sat_den_o  = sat_den_q;

endmodule

`default_nettype wire

// File: src/rhc_round.sv
`default_nettype none

module rhc_round
  import rhc_pkg::*;
#(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned QW            = 17
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [ByteW-1:0]  hue_rem_i,
  input  wire logic [QW-1:0]     hue_quo_i,
  input  wire logic [ByteW-1:0]  hue_den_i,
  input  wire logic [ByteW-1:0]  sat_rem_i,
  input  wire logic [QW-1:0]     sat_quo_i,
  input  wire logic [ByteW-1:0]  sat_den_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [HueW-1:0]        hue_o,
  output logic [SatW-1:0]        saturation_o,
  output logic [ByteW-1:0]       brightness_o
);

  localparam int unsigned SumW = QW + 1;
  localparam logic [SumW-1:0] FullTurn = SumW'(TurnDeg) << HUE_FRAC_BITS;

  logic                  valid_q;
  logic                  hue_up, sat_up;
  logic [SumW-1:0]       hue_sum, sat_sum, hue_wrap;
  logic [SumW+SatW-1:0]  hue_ext, sat_ext;
  logic [HueW-1:0]       hue_q;
  logic [SatW-1:0]       sat_q;
  logic [ByteW-1:0]      bright_q;

  // Round to nearest: add one when twice the remainder reaches the divisor
  always_comb begin
    hue_up  = {hue_rem_i, 1'b0} >= {1'b0, hue_den_i};
    sat_up  = {sat_rem_i, 1'b0} >= {1'b0, sat_den_i};
    hue_sum = SumW'(hue_quo_i) + SumW'(hue_up);
    sat_sum = SumW'(sat_quo_i) + SumW'(sat_up);
    // Wrap a hue that rounds up to a full turn, zero it for a grey pixel
    if (hue_den_i == '0) begin
      hue_wrap = '0;
    end else if (hue_sum >= FullTurn) begin
      hue_wrap = hue_sum - FullTurn;
    end else begin
      hue_wrap = hue_sum;
    end
    // Zero the saturation of a black pixel
    if (sat_den_i == '0) begin
      sat_sum = '0;
    end
    hue_ext = {{SatW{1'b0}}, hue_wrap};
    sat_ext = {{SatW{1'b0}}, sat_sum};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the result until the receiver takes the beat
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      hue_q    <= hue_ext[HueW-1:0];
      sat_q    <= sat_ext[SatW-1:0];
      bright_q <= sat_den_i;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

`default_nettype wire

// File: src/rgb_to_hsv_convert.sv
// RGB to HSV pixel converter.
// Input stream: one 8-bit RGB pixel per beat on s_axis_tdata, red in the low
// byte, then green, then blue. Output stream: one HSV result per pixel on
// m_axis_tdata: hue in degrees with HUE_FRAC_BITS fraction bits (15 bits),
// saturation chroma/max with SAT_FRAC_BITS fraction bits (17 bits), and
// brightness, the largest channel byte.
// Structure: a front stage finds max, min, chroma and the sector numerator,
// then a row of QW division cells (QW = max(HUE_FRAC_BITS + 9,
// SAT_FRAC_BITS + 1), 17 by default) each resolves one quotient bit of the
// hue and of the saturation division, and a last stage rounds and registers
// the result.
// Throughput: one pixel per cycle while the receiver keeps m_axis_tready
// high; every stage holds one pixel.
// Reset clears all stage valid flags; no pixel is in flight afterwards and
// s_axis_tready is high.
// Stall: when the receiver holds m_axis_tready low the result stays put; the
// stages behind it keep filling empty slots, and s_axis_tready drops only
// once every stage holds a pixel.
`default_nettype none

module rgb_to_hsv_convert
  import rhc_pkg::*;
#(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SAT_FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [14:0] hue, [31:15] saturation, [39:32] brightness
  output logic [39:0]      m_axis_tdata
);

  localparam int unsigned QW = (HUE_FRAC_BITS + HueIntW > SAT_FRAC_BITS + 1) ?
                               HUE_FRAC_BITS + HueIntW : SAT_FRAC_BITS + 1;

  logic             v_w    [QW+1];
  logic             rdy_w  [QW+1];
  logic [ByteW-1:0] hrem_w [QW+1];
  logic [QW-1:0]    hwrk_w [QW+1];
  logic [ByteW-1:0] hden_w [QW+1];
  logic [ByteW-1:0] srem_w [QW+1];
  logic [QW-1:0]    swrk_w [QW+1];
  logic [ByteW-1:0] sden_w [QW+1];

  logic [HueW-1:0]  hue;
  logic [SatW-1:0]  saturation;
  logic [ByteW-1:0] brightness;

  // Max, min, chroma and numerators
  rhc_front #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .SAT_FRAC_BITS(SAT_FRAC_BITS),
    .QW           (QW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .red_i     (s_axis_tdata[7:0]),
    .green_i   (s_axis_tdata[15:8]),
    .blue_i    (s_axis_tdata[23:16]),
    .valid_o   (v_w[0]),
    .ready_i   (rdy_w[0]),
    .hue_rem_o (hrem_w[0]),
    .hue_work_o(hwrk_w[0]),
    .hue_den_o (hden_w[0]),
    .sat_rem_o (srem_w[0]),
    .sat_work_o(swrk_w[0]),
    .sat_den_o (sden_w[0])
  );

  // Row of division cells, one quotient bit each
  for (genvar k = 0; k < QW; k++) begin : g_cell
    rhc_div_cell #(
      .QW(QW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (v_w[k]),
      .ready_o   (rdy_w[k]),
      .hue_rem_i (hrem_w[k]),
      .hue_work_i(hwrk_w[k]),
      .hue_den_i (hden_w[k]),
      .sat_rem_i (srem_w[k]),
      .sat_work_i(swrk_w[k]),
      .sat_den_i (sden_w[k]),
      .valid_o   (v_w[k+1]),
      .ready_i   (rdy_w[k+1]),
      .hue_rem_o (hrem_w[k+1]),
      .hue_work_o(hwrk_w[k+1]),
      .hue_den_o (hden_w[k+1]),
      .sat_rem_o (srem_w[k+1]),
      .sat_work_o(swrk_w[k+1]),
      .sat_den_o (sden_w[k+1])
    );
  end

  // Rounding and output register
  rhc_round #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .QW           (QW)
  ) u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v_w[QW]),
    .ready_o     (rdy_w[QW]),
    .hue_rem_i   (hrem_w[QW]),
    .hue_quo_i   (hwrk_w[QW]),
    .hue_den_i   (hden_w[QW]),
    .sat_rem_i   (srem_w[QW]),
    .sat_quo_i   (swrk_w[QW]),
    .sat_den_i   (sden_w[QW]),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .hue_o       (hue),
    .saturation_o(saturation),
    .brightness_o(brightness)
  );

  assign m_axis_tdata = {brightness, saturation, hue};

  // A black pixel has no saturation
  a_black_no_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && brightness == '0) |-> saturation == '0)
    else $error("nonzero saturation for a zero max");

  // Zero saturation only comes from a grey or black pixel, whose hue is zero
  a_grey_no_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && saturation == '0) |-> hue == '0)
    else $error("nonzero hue for a zero chroma");

  // Saturation never exceeds one (checked for SAT_FRAC_BITS of at most 16)
  a_sat_le_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (SAT_FRAC_BITS > 16 ||
                       saturation <= (SatW'(1) << SAT_FRAC_BITS)))
    else $error("saturation above one");

  // With the output stage empty every stage can advance
  a_empty_ready : assert property (@(posedge clk_i)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output is empty");

endmodule

`default_nettype wire
